FILE: hdl/acfr_pkg.sv
// Shared types, codes and helper functions of the command framer and reply checker.
`default_nettype none
package acfr_pkg;

	// Request codes on the input channel
	localparam logic [1:0] REQ_CMD  = 2'd0;
	localparam logic [1:0] REQ_RX   = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PERIOD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT    = 2'd1;

	localparam logic [15:0] MIN_PERIOD_RESET = 16'd30;
	localparam logic [15:0] TIMEOUT_RESET    = 16'd100;
	localparam logic [15:0] TIMER_MAX        = 16'hFFFF;

	// Characters and command opcodes
	localparam logic [7:0] CHAR_F      = 8'h46;
	localparam logic [7:0] CHAR_4      = 8'h34;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] OP_WRITE    = 8'h84;
	localparam logic [7:0] OP_READ     = 8'h04;

	// Reply characters that carry the hex value
	localparam logic [5:0] PARSE_FIRST = 6'd11;
	localparam logic [5:0] PARSE_LAST  = 6'd16;

	// Last character index of a frame: 'F', hex bytes, hex checksum, CR
	localparam logic [4:0] FRAME_LAST_WR = 5'd19;
	localparam logic [4:0] FRAME_LAST_RD = 5'd13;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_WAIT    = 2'd1,
		PH_COLLECT = 2'd2
	} phase_t;

	// One job from the front to the back: a frame to send or a completion
	typedef struct packed {
		logic            is_cmpl;
		logic            is_write;
		logic [8:0][7:0] frame;
		logic            success;
		logic [23:0]     read_value;
		logic [5:0]      chars_received;
	} job_t;

	// Decode an ASCII hex digit: bit 4 set when the character is a hex digit (0-9, A-F, a-f)
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	// Uppercase ASCII hex character of a nibble
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'd0, n};
		end else begin
			r = 8'h37 + {4'd0, n};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/acfr_intf.sv
// Handshake channel interfaces: input items, result items and configuration writes.
`default_nettype none
interface acfr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic        is_write;
	logic [7:0]  channel;
	logic [7:0]  window;
	logic [15:0] function_code;
	logic [23:0] payload;
	logic [7:0]  rx_byte;

	modport source (output valid, req_type, is_write, channel, window, function_code,
		payload, rx_byte, input ready);
	modport sink (input valid, req_type, is_write, channel, window, function_code,
		payload, rx_byte, output ready);
endinterface

interface acfr_rsp_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  tx_char;
	logic        last_char;
	logic        success;
	logic [23:0] read_value;
	logic [5:0]  chars_received;

	modport source (output valid, result_kind, tx_char, last_char, success, read_value,
		chars_received, input ready);
	modport sink (input valid, result_kind, tx_char, last_char, success, read_value,
		chars_received, output ready);
endinterface

interface acfr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/acfr_front.sv
// Front end: accepts items, runs the command/timer/reply state and issues jobs.
`default_nettype none
module acfr_front #(
	parameter int unsigned ACK_LENGTH = 20
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	acfr_req_if.sink     req,
	acfr_cfg_if.sink     cfg,
	input  wire logic    q_full,
	output acfr_pkg::job_t job,
	output logic         job_push
);

	localparam logic [5:0] ACK_LEN = 6'(ACK_LENGTH);

	acfr_pkg::phase_t phase_q, phase_d;
	logic [15:0] min_period_q, timeout_q;
	logic [15:0] timer_q, timer_d, timer_inc;
	logic        held_write_q, held_write_d;
	logic [7:0]  held_chan_q, held_chan_d;
	logic [7:0]  held_win_q, held_win_d;
	logic [15:0] held_func_q, held_func_d;
	logic [23:0] held_pay_q, held_pay_d;
	logic [5:0]  pos_q, pos_d, pos_inc;
	logic        status_q, status_d;
	logic [23:0] parsed_q, parsed_d;
	logic        stopped_q, stopped_d;
	logic        accept, send, cmpl, cmpl_full;
	logic [4:0]  hv;
	logic [7:0]  sum_rd, sum_wr;
	logic [7:0]  op;

	assign req.ready = !q_full;
	assign cfg.ready = 1'b1;
	assign accept    = req.valid && req.ready;
	assign timer_inc = (timer_q != acfr_pkg::TIMER_MAX) ? timer_q + 16'd1 : timer_q;
	assign pos_inc   = pos_q + 6'd1;
	assign hv        = acfr_pkg::hex_decode(req.rx_byte);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_period_q <= acfr_pkg::MIN_PERIOD_RESET;
			timeout_q    <= acfr_pkg::TIMEOUT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == acfr_pkg::CFG_MIN_PERIOD) begin
				min_period_q <= cfg.data;
			end else if (cfg.index == acfr_pkg::CFG_TIMEOUT) begin
				timeout_q <= cfg.data;
			end
		end
	end

	// Next state for one accepted item
	always_comb begin
		phase_d      = phase_q;
		timer_d      = timer_q;
		held_write_d = held_write_q;
		held_chan_d  = held_chan_q;
		held_win_d   = held_win_q;
		held_func_d  = held_func_q;
		held_pay_d   = held_pay_q;
		pos_d        = pos_q;
		status_d     = status_q;
		parsed_d     = parsed_q;
		stopped_d    = stopped_q;
		send         = 1'b0;
		cmpl         = 1'b0;
		cmpl_full    = 1'b0;
		if (accept) begin
			case (req.req_type)
				acfr_pkg::REQ_CMD: begin
					if (phase_q != acfr_pkg::PH_WAIT && phase_q != acfr_pkg::PH_COLLECT) begin
						held_write_d = req.is_write;
						held_chan_d  = req.channel;
						held_win_d   = req.window;
						held_func_d  = req.function_code;
						held_pay_d   = req.payload;
						phase_d      = acfr_pkg::PH_WAIT;
						send         = (timer_q >= min_period_q);
					end
				end
				acfr_pkg::REQ_RX: begin
					if (phase_q == acfr_pkg::PH_COLLECT) begin
						if (pos_q == 6'd0) begin
							if (req.rx_byte == acfr_pkg::CHAR_F) begin
								pos_d = 6'd1;
							end
						end else begin
							if (pos_q == 6'd1) begin
								status_d = (req.rx_byte == acfr_pkg::CHAR_4);
							end
							if (pos_q >= acfr_pkg::PARSE_FIRST && pos_q <= acfr_pkg::PARSE_LAST
									&& !stopped_q) begin
								if (hv[4]) begin
									parsed_d = {parsed_q[19:0], hv[3:0]};
								end else begin
									stopped_d = 1'b1;
								end
							end
							pos_d = pos_inc;
							if (pos_inc >= ACK_LEN) begin
								cmpl      = 1'b1;
								cmpl_full = 1'b1;
								phase_d   = acfr_pkg::PH_IDLE;
							end
						end
					end
				end
				acfr_pkg::REQ_TICK: begin
					timer_d = timer_inc;
					if (phase_q == acfr_pkg::PH_WAIT) begin
						send = (timer_inc >= min_period_q);
					end else if (phase_q == acfr_pkg::PH_COLLECT) begin
						if (timer_inc >= timeout_q) begin
							cmpl    = 1'b1;
							phase_d = acfr_pkg::PH_IDLE;
						end
					end
				end
				default: begin
				end
			endcase
			// Start reply collection once the frame is issued
			if (send) begin
				timer_d   = 16'd0;
				pos_d     = 6'd0;
				status_d  = 1'b0;
				parsed_d  = 24'd0;
				stopped_d = 1'b0;
				phase_d   = acfr_pkg::PH_COLLECT;
			end
		end
	end

	// Build the job: frame bytes with checksum, or completion status
	assign op     = held_write_d ? acfr_pkg::OP_WRITE : acfr_pkg::OP_READ;
	assign sum_rd = 8'(op + held_chan_d + held_win_d + held_func_d[15:8] + held_func_d[7:0]);
	assign sum_wr = 8'(sum_rd + held_pay_d[23:16] + held_pay_d[15:8] + held_pay_d[7:0]);

	always_comb begin
		job_push           = send || cmpl;
		job.is_cmpl        = cmpl;
		job.is_write       = held_write_d;
		job.frame[0]       = op;
		job.frame[1]       = held_chan_d;
		job.frame[2]       = held_win_d;
		job.frame[3]       = held_func_d[15:8];
		job.frame[4]       = held_func_d[7:0];
		job.frame[5]       = held_write_d ? held_pay_d[23:16] : sum_rd;
		job.frame[6]       = held_pay_d[15:8];
		job.frame[7]       = held_pay_d[7:0];
		job.frame[8]       = sum_wr;
		job.success        = cmpl_full && status_d && (!held_write_q || parsed_d == held_pay_q);
		job.read_value     = parsed_d;
		job.chars_received = pos_d;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= acfr_pkg::PH_IDLE;
			timer_q      <= 16'd0;
			held_write_q <= 1'b0;
			held_chan_q  <= 8'd0;
			held_win_q   <= 8'd0;
			held_func_q  <= 16'd0;
			held_pay_q   <= 24'd0;
			pos_q        <= 6'd0;
			status_q     <= 1'b0;
			parsed_q     <= 24'd0;
			stopped_q    <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			timer_q      <= timer_d;
			held_write_q <= held_write_d;
			held_chan_q  <= held_chan_d;
			held_win_q   <= held_win_d;
			held_func_q  <= held_func_d;
			held_pay_q   <= held_pay_d;
			pos_q        <= pos_d;
			status_q     <= status_d;
			parsed_q     <= parsed_d;
			stopped_q    <= stopped_d;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/acfr_queue.sv
// Short job queue between front and back, head shown without a read latency.
`default_nettype none
module acfr_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire acfr_pkg::job_t push_job,
	input  wire logic           pop,
	output acfr_pkg::job_t      head,
	output logic                head_valid,
	output logic                full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	acfr_pkg::job_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign head_valid = (cnt_q != '0);
	assign full       = (cnt_q == CNT_FULL);
	assign head       = slot_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Store pushed job
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/acfr_back.sv
// Back end: serializes frame jobs into characters and emits completions.
`default_nettype none
module acfr_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire acfr_pkg::job_t head,
	input  wire logic           head_valid,
	output logic                pop,
	acfr_rsp_if.source          rsp
);

	logic [4:0] idx_q;
	logic [4:0] last_idx, nib_idx;
	logic [7:0] cur_byte;
	logic [3:0] nib;
	logic [7:0] ch;
	logic       fire, at_last;
	logic       out_valid_q;
	logic       kind_q, last_q, ok_q;
	logic [7:0] char_q;
	logic [23:0] value_q;
	logic [5:0]  count_q;

	// Select the character at the current frame position
	assign last_idx = head.is_write ? acfr_pkg::FRAME_LAST_WR : acfr_pkg::FRAME_LAST_RD;
	assign at_last  = (idx_q == last_idx);
	assign nib_idx  = idx_q - 5'd1;
	assign cur_byte = head.frame[nib_idx[4:1]];
	assign nib      = nib_idx[0] ? cur_byte[3:0] : cur_byte[7:4];

	always_comb begin
		if (idx_q == 5'd0) begin
			ch = acfr_pkg::CHAR_F;
		end else if (at_last) begin
			ch = acfr_pkg::CHAR_CR;
		end else begin
			ch = acfr_pkg::hex_char(nib);
		end
	end

	assign fire = head_valid && (!out_valid_q || rsp.ready);
	assign pop  = fire && (head.is_cmpl || at_last);

	// Advance frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 5'd0;
		end else if (fire) begin
			idx_q <= (head.is_cmpl || at_last) ? 5'd0 : idx_q + 5'd1;
		end
	end

	// Hold result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q  <= head.is_cmpl;
			char_q  <= head.is_cmpl ? 8'd0 : ch;
			last_q  <= !head.is_cmpl && at_last;
			ok_q    <= head.is_cmpl && head.success;
			value_q <= head.is_cmpl ? head.read_value : 24'd0;
			count_q <= head.is_cmpl ? head.chars_received : 6'd0;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.result_kind    = kind_q;
	assign rsp.tx_char        = char_q;
	assign rsp.last_char      = last_q;
	assign rsp.success        = ok_q;
	assign rsp.read_value     = value_q;
	assign rsp.chars_received = count_q;

endmodule
`default_nettype wire

FILE: hdl/ascii_hex_command_framer_ack_checker_top.sv
// Top level of the ASCII hex command framer and reply checker.
// The input channel takes one item (command, received byte or millisecond tick) every
// clock cycle; it stalls only while the job queue (QUEUE_DEPTH entries) is full. Each
// item updates the command, timer and reply state in the same cycle and at most one
// job is queued: a frame or a completion. The back end drains jobs at one result per
// cycle while rsp.ready allows: 20 characters per write frame, 14 per read and 1 per
// completion. The front keeps running while a result waits in the output register.
// Configuration writes are always accepted and take effect on the next cycle.
`default_nettype none
module ascii_hex_command_framer_ack_checker_top #(
	parameter int unsigned ACK_LENGTH  = 20,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	acfr_req_if.sink   req,
	acfr_rsp_if.source rsp,
	acfr_cfg_if.sink   cfg
);

	acfr_pkg::job_t push_job, head;
	logic           push, pop, head_valid, full;

	acfr_front #(
		.ACK_LENGTH (ACK_LENGTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.q_full   (full),
		.job      (push_job),
		.job_push (push)
	);

	acfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	acfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule
`default_nettype wire
